/* rtl/core/mclw_pkg.sv */
// ----------------------------------------------------------------------------
// Liveness watchdog package
// Shared sizes, codes and transfer payload types of the multi-channel
// liveness watchdog.
// ----------------------------------------------------------------------------
`default_nettype none

package mclw_pkg;

   localparam int CHANNELS = 4;
   localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   localparam int TIME_W  = 32;
   localparam int TALLY_W = 16;
   localparam int MASK_W  = 4;
   localparam int CID_W   = 2;
   localparam int CSR_IDX_W = 3;

   typedef logic [CH_IDX_W-1:0] idx_type;
   typedef logic [TIME_W-1:0]   time_type;
   typedef logic [TALLY_W-1:0]  tally_type;
   typedef logic [MASK_W-1:0]   mask_type;
   typedef logic [CID_W-1:0]    cid_type;

   localparam logic [1:0] REQ_PING     = 2'd0;
   localparam logic [1:0] REQ_CHECK    = 2'd1;
   localparam logic [1:0] REQ_START    = 2'd2;
   localparam logic [1:0] REQ_RESERVED = 2'd3;

   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRACE      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GRACE_MODE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REPORT_INT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CHECK_INT  = 3'd4;

   localparam time_type TIMEOUT_RESET    = 32'd60000;
   localparam time_type GRACE_RESET      = 32'd5000;
   localparam time_type REPORT_INT_RESET = 32'd10000;
   localparam time_type CHECK_INT_RESET  = 32'd1000;

   typedef struct packed {
      logic [1:0] req_type;
      cid_type    channel_id;
      time_type   now_ms;
   } req_item_type;

   typedef struct packed {
      logic      item_kind;
      logic      healthy;
      logic      reset_request;
      mask_type  timed_out_mask;
      cid_type   report_channel;
      tally_type report_count;
      time_type  report_elapsed_ms;
      logic      last_of_run;
   } rsp_item_type;

endpackage

`default_nettype wire

/* rtl/core/multi_channel_liveness_watchdog_unit.sv */
// ----------------------------------------------------------------------------
// Multi-channel liveness watchdog
// Tracks per-channel ping times and tallies in two small synchronous
// memories and reports timeouts, reset requests and periodic ping counts.
// ----------------------------------------------------------------------------
`default_nettype none

// One item is worked on at a time. A start item writes the channel times one
// entry at a time and gives no result. A throttled check item gives a healthy
// status without a walk; a ping item first does the tally read-modify-write.
// A full check reads the channel times one entry per cycle from a single read
// port, and a report then reads and clears the tallies one entry at a time.
// A result transfer that is held back stalls the block until it is taken.
// The output is registered, so the next input transfer is taken while the
// last result is still waiting. Reserved request types are dropped.
module multi_channel_liveness_watchdog_unit (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire mclw_pkg::req_item_type req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output mclw_pkg::rsp_item_type      rsp_data,
   input  wire logic                   csr_write_enable,
   input  wire logic [mclw_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [mclw_pkg::TIME_W-1:0]    csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_PING,
      ST_CHECK,
      ST_WALK,
      ST_STATUS,
      ST_REPORT
   } state_type;

   state_type state_ff, state_in;

   mclw_pkg::time_type  now_ff, now_in;
   mclw_pkg::idx_type   idx_ff, idx_in;
   logic                ok_ff, ok_in;
   logic                rst_ff, rst_in;
   mclw_pkg::mask_type  mask_ff, mask_in;
   logic                report_ff, report_in;
   mclw_pkg::time_type  since_ff, since_in;
   mclw_pkg::time_type  report_stamp_ff, report_stamp_in;
   mclw_pkg::time_type  check_stamp_ff, check_stamp_in;

   mclw_pkg::time_type  timeout_ff, grace_ff, report_int_ff, check_int_ff;
   logic                grace_mode_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   mclw_pkg::rsp_item_type rsp_data_ff, rsp_data_in;

   mclw_pkg::time_type  time_mem [mclw_pkg::CHANNELS];
   mclw_pkg::tally_type tally_mem [mclw_pkg::CHANNELS];
   logic [mclw_pkg::CHANNELS-1:0] time_vld_ff, tally_vld_ff;
   mclw_pkg::time_type  time_rd_ff;
   mclw_pkg::tally_type tally_rd_ff;
   logic                time_rd_vld_ff, tally_rd_vld_ff;

   logic                time_we, tally_we;
   mclw_pkg::time_type  time_wdata;
   mclw_pkg::tally_type tally_wdata;

   mclw_pkg::time_type  seen_time, silent, check_age, report_age;
   mclw_pkg::tally_type tally_cur;
   logic [mclw_pkg::TIME_W:0] grace_sum;
   logic                out_free, throttled, over_limit, beyond_grace, idx_last, ping_ok;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign seen_time  = time_rd_vld_ff ? time_rd_ff : '0;
   assign tally_cur  = tally_rd_vld_ff ? tally_rd_ff : '0;
   assign silent     = now_ff - seen_time;
   assign check_age  = now_ff - check_stamp_ff;
   assign report_age = now_ff - report_stamp_ff;
   assign throttled  = check_age < check_int_ff;
   assign grace_sum  = {1'b0, timeout_ff} + {1'b0, grace_ff};
   assign over_limit = silent > timeout_ff;
   assign beyond_grace = {1'b0, silent} > grace_sum;
   assign idx_last   = (idx_ff == mclw_pkg::idx_type'(mclw_pkg::CHANNELS - 1));
   assign ping_ok    = {3'b000, req_data.channel_id} < 5'(mclw_pkg::CHANNELS);

   always_comb begin
      state_in        = state_ff;
      now_in          = now_ff;
      idx_in          = idx_ff;
      ok_in           = ok_ff;
      rst_in          = rst_ff;
      mask_in         = mask_ff;
      report_in       = report_ff;
      since_in        = since_ff;
      report_stamp_in = report_stamp_ff;
      check_stamp_in  = check_stamp_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_data_in     = rsp_data_ff;
      time_we         = 1'b0;
      tally_we        = 1'b0;
      time_wdata      = now_ff;
      tally_wdata     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               now_in  = req_data.now_ms;
               idx_in  = '0;
               priority if (req_data.req_type == mclw_pkg::REQ_RESERVED) begin
                  state_in = ST_IDLE;
               end else if (req_data.req_type == mclw_pkg::REQ_START) begin
                  state_in = ST_START;
               end else if (req_data.req_type == mclw_pkg::REQ_PING && ping_ok) begin
                  idx_in   = mclw_pkg::idx_type'(req_data.channel_id);
                  state_in = ST_PING;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_START: begin
            time_we = 1'b1;
            if (idx_last) begin
               report_stamp_in = now_ff;
               state_in        = ST_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_PING: begin
            time_we     = 1'b1;
            tally_we    = 1'b1;
            tally_wdata = (tally_cur == '1) ? tally_cur
                        : mclw_pkg::tally_type'(tally_cur + 1'b1);
            state_in    = ST_CHECK;
         end
         ST_CHECK: begin
            if (throttled) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '0;
                  rsp_data_in.item_kind   = mclw_pkg::KIND_STATUS;
                  rsp_data_in.healthy     = 1'b1;
                  rsp_data_in.last_of_run = 1'b1;
                  state_in = ST_IDLE;
               end
            end else begin
               check_stamp_in = now_ff;
               ok_in     = 1'b1;
               rst_in    = 1'b0;
               mask_in   = '0;
               report_in = !(report_age < report_int_ff);
               since_in  = report_age;
               idx_in    = '0;
               state_in  = ST_WALK;
            end
         end
         ST_WALK: begin
            if (over_limit) begin
               ok_in   = 1'b0;
               mask_in = mask_ff | (mclw_pkg::mask_type'(1) << idx_ff);
               if (!grace_mode_ff || beyond_grace) begin
                  rst_in = 1'b1;
               end
            end
            if (idx_last) begin
               state_in = ST_STATUS;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_STATUS: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_data_in.item_kind      = mclw_pkg::KIND_STATUS;
               rsp_data_in.healthy        = ok_ff;
               rsp_data_in.reset_request  = rst_ff;
               rsp_data_in.timed_out_mask = mask_ff;
               rsp_data_in.last_of_run    = !report_ff;
               idx_in = '0;
               if (report_ff) begin
                  report_stamp_in = now_ff;
                  state_in        = ST_REPORT;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_REPORT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_data_in.item_kind         = mclw_pkg::KIND_REPORT;
               rsp_data_in.report_channel    = mclw_pkg::cid_type'(idx_ff);
               rsp_data_in.report_count      = tally_cur;
               rsp_data_in.report_elapsed_ms = since_ff;
               rsp_data_in.last_of_run       = idx_last;
               tally_we    = 1'b1;
               tally_wdata = '0;
               if (idx_last) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         report_stamp_ff <= '0;
         check_stamp_ff  <= '0;
         time_vld_ff     <= '0;
         tally_vld_ff    <= '0;
         timeout_ff      <= mclw_pkg::TIMEOUT_RESET;
         grace_ff        <= mclw_pkg::GRACE_RESET;
         grace_mode_ff   <= 1'b0;
         report_int_ff   <= mclw_pkg::REPORT_INT_RESET;
         check_int_ff    <= mclw_pkg::CHECK_INT_RESET;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         report_stamp_ff <= report_stamp_in;
         check_stamp_ff  <= check_stamp_in;
         if (time_we) begin
            time_vld_ff[idx_ff] <= 1'b1;
         end
         if (tally_we) begin
            tally_vld_ff[idx_ff] <= 1'b1;
         end
         if (csr_write_enable) begin
            unique case (csr_index)
               mclw_pkg::CSR_TIMEOUT:    timeout_ff    <= csr_wdata;
               mclw_pkg::CSR_GRACE:      grace_ff      <= csr_wdata;
               mclw_pkg::CSR_GRACE_MODE: grace_mode_ff <= csr_wdata[0];
               mclw_pkg::CSR_REPORT_INT: report_int_ff <= csr_wdata;
               mclw_pkg::CSR_CHECK_INT:  check_int_ff  <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
      now_ff          <= now_in;
      idx_ff          <= idx_in;
      ok_ff           <= ok_in;
      rst_ff          <= rst_in;
      mask_ff         <= mask_in;
      report_ff       <= report_in;
      since_ff        <= since_in;
      rsp_data_ff     <= rsp_data_in;
      time_rd_vld_ff  <= time_vld_ff[idx_in] && !reset;
      tally_rd_vld_ff <= tally_vld_ff[idx_in] && !reset;
   end

   // The walk never reads an entry in the cycle that entry is written.
   always_ff @(posedge clock) begin
      if (time_we) begin
         time_mem[idx_ff] <= time_wdata;
      end
      if (tally_we) begin
         tally_mem[idx_ff] <= tally_wdata;
      end
      time_rd_ff  <= time_mem[idx_in];
      tally_rd_ff <= tally_mem[idx_in];
   end

`ifndef SYNTHESIS
   a_walk_flow: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |=> state_ff == ST_WALK || state_ff == ST_STATUS)
      else $error("walk left toward an unexpected state");

   a_walk_stamp: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> check_stamp_ff == now_ff)
      else $error("check stamp not taken at full check");

   a_report_load: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_REPORT && out_free
      |=> rsp_valid_ff && rsp_data_ff.item_kind == mclw_pkg::KIND_REPORT)
      else $error("report entry not loaded");

   a_throttle_load: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CHECK && throttled && out_free
      |=> rsp_valid_ff && rsp_data_ff.healthy && rsp_data_ff.last_of_run
          && state_ff == ST_IDLE)
      else $error("throttled check did not report healthy");
`endif

endmodule

`default_nettype wire
